>>> hw/rtl/csse_pkg.sv
// shared types and constants for the cubic spline segment evaluator
// no dependencies
`default_nettype none

package csse_pkg;

  localparam int NW    = 136;
  localparam int OW    = 35;
  localparam int PW    = 2 * OW;
  localparam int VW    = 35;
  localparam int SPLIT = 35;
  localparam int PSPLIT = 33;
  localparam int ZW    = 106;
  localparam int BW    = 72;
  localparam int HW    = 33;
  localparam int KW    = 35;
  localparam int DW    = KW + 1;
  localparam int QW    = 31;

  localparam logic [1:0] FN_VALUE = 2'd0;
  localparam logic [1:0] FN_SLOPE = 2'd1;
  localparam logic [1:0] FN_CURV  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic signed [31:0] RES_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] x_lo;
    logic signed [31:0] y_lo;
    logic signed [31:0] curv_lo;
    logic signed [31:0] x_hi;
    logic signed [31:0] y_hi;
    logic signed [31:0] curv_hi;
    logic signed [31:0] x_query;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } resp_t;

  typedef struct packed {
    logic [1:0]    func;
    logic          zero;
    logic          hneg;
    logic [HW-1:0] habs;
  } meta_t;

  typedef struct packed {
    logic zero;
    logic neg;
    logic ovf;
  } dside_t;

  typedef struct packed {
    dside_t        side;
    logic [DW-1:0] rem;
    logic [QW-1:0] ulo;
    logic [DW-1:0] dv;
  } div_in_t;

endpackage

`default_nettype wire

>>> hw/rtl/csse_poly.sv
// numerator pipeline: knot differences, two multiplier levels, final sum
// depends on csse_pkg
`default_nettype none

module csse_poly
  import csse_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 req_valid,
  input  wire req_t                 req,
  output logic                      num_valid,
  output logic signed [NW-1:0]      num,
  output meta_t                     num_meta
);

  // stage 1
  logic v1;
  meta_t meta1;
  logic signed [OW-1:0] a1, b1, h1, ah1, bh1, dc1, dy1, yl1, yh1, cl1, ch1;
  logic signed [OW-1:0] xl_e, xh_e, xq_e, yl_e, yh_e, cl_e, ch_e, h_c;
  logic [HW-1:0] habs_c;

  always_comb begin
    xl_e = OW'($signed(req.x_lo));
    xh_e = OW'($signed(req.x_hi));
    xq_e = OW'($signed(req.x_query));
    yl_e = OW'($signed(req.y_lo));
    yh_e = OW'($signed(req.y_hi));
    cl_e = OW'($signed(req.curv_lo));
    ch_e = OW'($signed(req.curv_hi));
    h_c  = xh_e - xl_e;
    habs_c = h_c[OW-1] ? HW'(-h_c) : HW'(h_c);
  end

  // stage 2
  logic v2;
  meta_t meta2;
  logic signed [OW-1:0] a2, b2, h2, dy2;
  logic signed [PW-1:0] m0, m1, m2, m3, m4;
  logic is_val1;
  logic signed [OW-1:0] op0b, op1b, op2a, op2b;

  always_comb begin
    is_val1 = (meta1.func != FN_SLOPE) && (meta1.func != FN_CURV);
    op0b = is_val1 ? yl1 : cl1;
    op1b = is_val1 ? yh1 : ch1;
    op2a = is_val1 ? ah1 : dc1;
    op2b = is_val1 ? cl1 : h1;
  end

  // stage 3
  logic v3;
  meta_t meta3;
  logic signed [OW-1:0] dy3;
  logic signed [PW-1:0] l3;
  logic signed [PW-1:0] w3 [3];
  logic signed [VW-1:0] u3 [3];
  logic is_val2;
  logic signed [PW-1:0] t_c;

  always_comb begin
    is_val2 = (meta2.func != FN_SLOPE) && (meta2.func != FN_CURV);
    t_c = m2 + m3;
  end

  // stage 4
  logic v4;
  meta_t meta4;
  logic signed [PW-1:0] l4;
  logic signed [BW-1:0] base4;
  logic signed [PW:0]   pl4 [3];
  logic signed [PW-1:0] ph4 [3];
  logic signed [BW-1:0] six_in;

  always_comb begin
    six_in = (meta3.func == FN_SLOPE) ? BW'(dy3) : BW'(l3);
  end

  // stage 5
  logic v5;
  meta_t meta5;
  logic signed [PW-1:0] l5;
  logic signed [NW-1:0] base5;
  logic signed [ZW-1:0] z5 [3];

  // stage 6
  logic v6;
  meta_t meta6;
  logic signed [PW-1:0] l6;
  logic signed [NW-1:0] base6, e6;
  logic signed [ZW-1:0] z6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      num_valid <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      num_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= xh_e - xq_e;
      b1  <= xq_e - xl_e;
      h1  <= h_c;
      ah1 <= xh_e + xh_e - xq_e - xl_e;
      bh1 <= xq_e + xh_e - xl_e - xl_e;
      dc1 <= ch_e - cl_e;
      dy1 <= yh_e - yl_e;
      yl1 <= yl_e;
      yh1 <= yh_e;
      cl1 <= cl_e;
      ch1 <= ch_e;
      meta1 <= '{func: req.func, zero: (req.x_hi == req.x_lo),
                 hneg: h_c[OW-1], habs: habs_c};

      m0 <= PW'(a1 * op0b);
      m1 <= PW'(b1 * op1b);
      m2 <= PW'(op2a * op2b);
      m3 <= PW'(bh1 * ch1);
      m4 <= PW'(a1 * b1);
      a2 <= a1;
      b2 <= b1;
      h2 <= h1;
      dy2 <= dy1;
      meta2 <= meta1;

      l3 <= m0 + m1;
      dy3 <= dy2;
      meta3 <= meta2;
      if (is_val2) begin
        w3[0] <= t_c;
        u3[0] <= $signed({2'b00, m4[PSPLIT-1:0]});
        w3[1] <= t_c;
        u3[1] <= VW'($signed(m4[2*PSPLIT:PSPLIT]));
        w3[2] <= '0;
        u3[2] <= '0;
      end else begin
        w3[0] <= m0;
        u3[0] <= VW'(a2);
        w3[1] <= m1;
        u3[1] <= VW'(b2);
        w3[2] <= m2;
        u3[2] <= VW'(h2);
      end

      for (int i = 0; i < 3; i++) begin
        pl4[i] <= (PW+1)'($signed({1'b0, w3[i][SPLIT-1:0]}) * u3[i]);
        ph4[i] <= PW'($signed(w3[i][PW-1:SPLIT]) * u3[i]);
      end
      base4 <= (six_in <<< 2) + (six_in <<< 1);
      l4 <= l3;
      meta4 <= meta3;

      for (int i = 0; i < 3; i++) begin
        z5[i] <= (ZW'(ph4[i]) <<< SPLIT) + ZW'(pl4[i]);
      end
      base5 <= NW'(base4) <<< (2 * FRAC_BITS);
      l5 <= l4;
      meta5 <= meta4;

      if (meta5.func == FN_SLOPE) begin
        e6 <= NW'(z5[1]) - NW'(z5[0]);
      end else begin
        e6 <= NW'(z5[0]) + (NW'(z5[1]) <<< PSPLIT);
      end
      z6 <= z5[2];
      base6 <= base5;
      l6 <= l5;
      meta6 <= meta5;

      case (meta6.func)
        FN_SLOPE: num <= base6 + e6 + (e6 <<< 1) - NW'(z6);
        FN_CURV:  num <= NW'(l6);
        default:  num <= base6 - e6;
      endcase
      num_meta <= meta6;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/csse_norm.sv
// sign fold, rounding offset, scale shift and range check ahead of the divider
// depends on csse_pkg
`default_nettype none

module csse_norm
  import csse_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 num_valid,
  input  wire logic signed [NW-1:0] num,
  input  wire meta_t                num_meta,
  output logic                      load_valid,
  output div_in_t                   load
);

  logic v8, v9, v10;
  logic signed [NW-1:0] n8, n9;
  logic [KW-1:0] d8, d9, d10;
  logic [1:0] func8, func9;
  logic zero8, zero9, zero10, neg10;
  logic [NW-1:0] u10;

  logic [KW-1:0] habs_e;
  logic signed [NW-1:0] dk, m_c;
  logic [DW-1:0] dv_c;

  always_comb begin
    habs_e = KW'(num_meta.habs);
    case (func8)
      FN_CURV:  dk = $signed(NW'(d8));
      FN_SLOPE: dk = $signed(NW'(d8)) <<< FRAC_BITS;
      default:  dk = $signed(NW'(d8)) <<< (2 * FRAC_BITS);
    endcase
    case (func9)
      FN_CURV:  m_c = n9;
      FN_SLOPE: m_c = n9 >>> FRAC_BITS;
      default:  m_c = n9 >>> (2 * FRAC_BITS);
    endcase
    dv_c = {d10, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      load_valid <= 1'b0;
    end else if (en) begin
      v8 <= num_valid;
      v9 <= v8;
      v10 <= v9;
      load_valid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n8 <= num_meta.hneg ? -num : num;
      d8 <= (num_meta.func == FN_CURV) ? habs_e : (habs_e << 2) + (habs_e << 1);
      func8 <= num_meta.func;
      zero8 <= num_meta.zero;

      n9 <= (n8 <<< 1) + dk;
      d9 <= d8;
      func9 <= func8;
      zero9 <= zero8;

      neg10 <= m_c[NW-1];
      u10 <= m_c[NW-1] ? ~m_c : m_c;
      d10 <= d9;
      zero10 <= zero9;

      load.side.zero <= zero10;
      load.side.neg <= neg10;
      load.side.ovf <= u10 >= (NW'(dv_c) << QW);
      load.rem <= DW'(u10 >> QW);
      load.ulo <= u10[QW-1:0];
      load.dv <= dv_c;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/csse_div.sv
// restoring divider, one quotient bit per pipeline stage
// depends on csse_pkg
`default_nettype none

module csse_div
  import csse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     load_valid,
  input  wire div_in_t  load,
  output logic          done_valid,
  output dside_t        done_side,
  output logic [QW-1:0] quotient
);

  logic          vld  [QW];
  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] ulo  [QW];
  logic [QW-1:0] quo  [QW];
  logic [DW-1:0] dv   [QW];
  dside_t        side [QW];

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic          vin;
    logic [DW-1:0] rin, din;
    logic [QW-1:0] uin, qin;
    dside_t        sin;
    logic [DW:0]   trial;
    logic          take;

    if (g == 0) begin : g_first
      assign vin = load_valid;
      assign rin = load.rem;
      assign din = load.dv;
      assign uin = load.ulo;
      assign qin = '0;
      assign sin = load.side;
    end else begin : g_rest
      assign vin = vld[g-1];
      assign rin = rem[g-1];
      assign din = dv[g-1];
      assign uin = ulo[g-1];
      assign qin = quo[g-1];
      assign sin = side[g-1];
    end

    assign trial = {rin, uin[QW-1-g]};
    assign take  = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= take ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
        quo[g]  <= {qin[QW-2:0], take};
        ulo[g]  <= uin;
        dv[g]   <= din;
        side[g] <= sin;
      end
    end
  end

  assign done_valid = vld[QW-1];
  assign done_side  = side[QW-1];
  assign quotient   = quo[QW-1];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    vld[QW-1] && !side[QW-1].ovf && !side[QW-1].zero |-> rem[QW-1] < dv[QW-1])
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> hw/rtl/cubic_spline_segment_eval_unit.sv
// top level of the cubic spline segment evaluator
// depends on csse_pkg, csse_poly, csse_norm, csse_div
//
// channel  side  payload  handshake
// req      in    req_t    req_valid / req_stall
// resp     out   resp_t   resp_valid / resp_stall
//
// takes one request per cycle while req_stall is low
// the pipeline is 7 numerator stages, 4 scaling stages, the 31-stage divider and the output register
// reset clears only the valid bits of the stages
// a stalled result freezes every stage and raises req_stall until it is taken
`default_nettype none

module cubic_spline_segment_eval_unit
  import csse_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  input  wire req_t  req,
  output logic       resp_valid,
  input  wire logic  resp_stall,
  output resp_t      resp
);

  logic en;
  logic num_valid;
  logic signed [NW-1:0] num;
  meta_t num_meta;
  logic load_valid;
  div_in_t load;
  logic done_valid;
  dside_t done_side;
  logic [QW-1:0] quotient;
  resp_t fmt;

  assign en = !resp_valid || !resp_stall;
  assign req_stall = !en;

  csse_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .num_valid (num_valid),
    .num       (num),
    .num_meta  (num_meta)
  );

  csse_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .num_valid  (num_valid),
    .num        (num),
    .num_meta   (num_meta),
    .load_valid (load_valid),
    .load       (load)
  );

  csse_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .load_valid (load_valid),
    .load       (load),
    .done_valid (done_valid),
    .done_side  (done_side),
    .quotient   (quotient)
  );

  always_comb begin
    if (done_side.zero) begin
      fmt.result = '0;
      fmt.status = ST_ZERO;
    end else if (done_side.ovf) begin
      fmt.result = done_side.neg ? RES_MIN : RES_MAX;
      fmt.status = ST_SAT;
    end else begin
      fmt.result = done_side.neg ? ~{1'b0, quotient} : {1'b0, quotient};
      fmt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (en) begin
      resp_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      resp <= fmt;
    end
  end

  a_zero_width_gives_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status == ST_ZERO |-> resp.result == '0)
    else $error("zero-width interval with nonzero result");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status == ST_SAT |-> resp.result == RES_MAX || resp.result == RES_MIN)
    else $error("saturated result not at a bound");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> resp.status == ST_OK || resp.status == ST_ZERO || resp.status == ST_SAT)
    else $error("undefined status code");

endmodule

`default_nettype wire

>>> tb/cubic_spline_segment_eval_unit_tb.sv
// testbench for cubic_spline_segment_eval_unit: exact-ratio spline predictor,
// directed corner cases then random requests, first with random idling on both sides, then without
// depends on csse_pkg and the unit rtl
`timescale 1ns / 1ps

module cubic_spline_segment_eval_unit_tb;
  import csse_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 680;
  localparam int N_STEADY = 100;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  resp_valid;
  logic  resp_stall = 1'b0;
  resp_t resp;

  resp_t expected_q[$];
  int    errors = 0;
  bit    idle_en = 1'b1;
  int    stall_left = 0;

  cubic_spline_segment_eval_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .resp_valid(resp_valid), .resp_stall(resp_stall), .resp(resp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // exact rational evaluation, one rounding half up, then clamp
  function automatic resp_t spline_eval(req_t r);
    logic signed [255:0] xl, yl, cl, xh, yh, ch, xq, h, a, b, h2, num, dk, den, q;
    resp_t o;
    int k;
    int m;
    xl = r.x_lo; yl = r.y_lo; cl = r.curv_lo;
    xh = r.x_hi; yh = r.y_hi; ch = r.curv_hi;
    xq = r.x_query;
    h = xh - xl;
    if (h == 0) begin
      o.result = '0;
      o.status = ST_ZERO;
      return o;
    end
    a = xh - xq;
    b = xq - xl;
    h2 = h * h;
    case (r.func)
      FN_CURV: begin
        num = a * cl + b * ch;
        m = 1;
        k = 0;
      end
      FN_SLOPE: begin
        num = (((yh - yl) * 6) <<< (2 * FRAC)) - a * a * cl * 3 + b * b * ch * 3
              - (ch - cl) * h2;
        m = 6;
        k = FRAC;
      end
      default: begin
        num = (((a * yl + b * yh) * 6) <<< (2 * FRAC))
              + (a * a * a - a * h2) * cl + (b * b * b - b * h2) * ch;
        m = 6;
        k = 2 * FRAC;
      end
    endcase
    if (h < 0) begin
      num = -num;
      h = -h;
    end
    dk = (h * m) <<< k;
    num = (num <<< 1) + dk;
    den = dk <<< 1;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    if (q > RES_MAX) begin
      o.result = RES_MAX;
      o.status = ST_SAT;
    end else if (q < RES_MIN) begin
      o.result = RES_MIN;
      o.status = ST_SAT;
    end else begin
      o.result = q[31:0];
      o.status = ST_OK;
    end
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic idle_req(int n);
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  task automatic send_req(req_t r);
    if (idle_en && $urandom_range(0, 5) == 0) idle_req($urandom_range(1, 6));
    @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    expected_q.push_back(spline_eval(r));
  endtask

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (idle_en && stall_left > 0) begin
      stall_left <= stall_left - 1;
      resp_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      resp_stall <= 1'b1;
    end else begin
      resp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    resp_t exp_r;
    if (!rst && resp_valid && !resp_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_r = expected_q.pop_front();
        if (resp.result !== exp_r.result)
          report_mismatch($sformatf("result %h expected %h", resp.result, exp_r.result));
        if (resp.status !== exp_r.status)
          report_mismatch($sformatf("status %0d expected %0d", resp.status, exp_r.status));
      end
    end
  end

  function automatic req_t make_req(logic [1:0] f, int xl, int yl, int cl, int xh, int yh,
                                    int ch, int xq);
    req_t r;
    r.func = f; r.x_lo = xl; r.y_lo = yl; r.curv_lo = cl;
    r.x_hi = xh; r.y_hi = yh; r.curv_hi = ch; r.x_query = xq;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.func = 2'($urandom_range(0, 3));
    r.x_lo = rand_q();
    r.y_lo = rand_q();
    r.curv_lo = rand_q();
    r.y_hi = rand_q();
    r.curv_hi = rand_q();
    case ($urandom_range(0, 9))
      0: r.x_hi = r.x_lo;
      1: r.x_hi = $urandom();
      default: r.x_hi = r.x_lo + $signed($urandom_range(1, 32'h0008_0000))
                        * ($urandom_range(0, 3) == 0 ? -1 : 1);
    endcase
    case ($urandom_range(0, 4))
      0: r.x_query = $urandom();
      1: r.x_query = r.x_lo;
      2: r.x_query = r.x_hi;
      default: r.x_query = r.x_lo + (r.x_hi - r.x_lo) / 2 + $signed($urandom_range(0, 4096))
                           - 2048;
    endcase
    return r;
  endfunction

  task automatic test_modes();
    logic [1:0] f;
    for (int i = 0; i < 4; i++) begin
      f = 2'(i);
      send_req(make_req(f, 0, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0003_0000,
                        -32'sh0001_0000, 32'h0000_8000));
      send_req(make_req(f, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 0, -32'sh0001_0000,
                        32'h0003_0000, 32'h0001_0000));
    end
  endtask

  task automatic test_zero_width();
    send_req(make_req(FN_VALUE, 32'h0001_0000, 5, 6, 32'h0001_0000, 7, 8, 9));
    send_req(make_req(FN_SLOPE, RES_MIN, RES_MAX, RES_MIN, RES_MIN, RES_MAX, RES_MIN, 0));
    send_req(make_req(FN_CURV, RES_MAX, 0, 0, RES_MAX, 0, 0, RES_MAX));
  endtask

  task automatic test_extremes();
    send_req(make_req(FN_VALUE, RES_MIN, RES_MAX, RES_MAX, RES_MAX, RES_MIN, RES_MIN, RES_MIN));
    send_req(make_req(FN_SLOPE, RES_MAX, RES_MIN, RES_MAX, RES_MIN, RES_MAX, RES_MIN, RES_MAX));
    send_req(make_req(FN_CURV, RES_MIN, 0, RES_MAX, RES_MAX, 0, RES_MAX, RES_MAX));
    send_req(make_req(FN_VALUE, 0, 0, 0, 1, 32'h7fff_0000, 0, RES_MAX));
    send_req(make_req(FN_SLOPE, 0, RES_MIN, 0, 1, RES_MAX, 0, 0));
    send_req(make_req(FN_CURV, -1, -1, -1, 0, -1, -1, -1));
    send_req(make_req(FN_VALUE, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0002_0000, 0,
                      32'h0100_0000));
    send_req(make_req(2'd3, 0, 32'h0001_0000, 32'h0010_0000, 32'h0001_0000, 0,
                      32'h0010_0000, -32'sh0000_4000));
  endtask

  task automatic test_random(int n);
    repeat (n) send_req(rand_req());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_modes();
    test_zero_width();
    test_extremes();
    test_random(N_RANDOM);
    idle_en = 1'b0;
    test_random(N_STEADY);
    idle_req(1);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
